### hdl/hta_pkg.sv
// ----------------------------------------------------------------------------
// hta_pkg - handle table allocator shared definitions
// Sizes, codes, state encoding and the structs passed between the table
// controller, the occupancy scanner and the slot memory.
// ----------------------------------------------------------------------------
package hta_pkg;

   localparam int CAPACITY     = 128;
   localparam int INITIAL_SIZE = 48;
   localparam int GROW_STEP    = 16;
   localparam int TABLE_INIT   = (INITIAL_SIZE > CAPACITY) ? CAPACITY : INITIAL_SIZE;

   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int SIZE_W = $clog2(CAPACITY + 1);
   localparam int SUM_W  = $clog2(CAPACITY + GROW_STEP + 1);

   localparam int CHUNK_W     = 8;
   localparam int CHUNK_LOG   = $clog2(CHUNK_W);
   localparam int NCHUNK      = (CAPACITY + CHUNK_W - 1) / CHUNK_W;
   localparam int CHUNK_IDX_W = $clog2(NCHUNK);
   localparam int SCAN_W      = CHUNK_IDX_W + CHUNK_LOG;

   localparam int HANDLE_W     = 31;
   localparam int OBJECT_W     = 16;
   localparam int TYPE_W       = 4;
   localparam int HANDLE_OUT_W = 8;
   localparam int STATUS_W     = 2;
   localparam int CSR_INDEX_W  = 4;

   localparam logic [HANDLE_W-1:0] SELF_HANDLE = 31'h7fffffff;

   localparam logic [CSR_INDEX_W-1:0] REG_SELF_OBJECT = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SELF_TYPE   = 4'd1;

   localparam logic [OBJECT_W-1:0] SELF_OBJECT_RESET = 16'd0;
   localparam logic [TYPE_W-1:0]   SELF_TYPE_RESET   = 4'd1;
   localparam logic [TYPE_W-1:0]   TYPE_ANY          = 4'd0;

   typedef enum logic [1:0] {
      ACT_ALLOC   = 2'd0,
      ACT_LOOKUP  = 2'd1,
      ACT_REPLACE = 2'd2,
      ACT_CLOSE   = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_NO_MEM  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]          action;
      logic [HANDLE_W-1:0] handle;
      logic [OBJECT_W-1:0] object;
      logic [TYPE_W-1:0]   object_type;
      logic [TYPE_W-1:0]   want_type;
   } req_item_type;

   typedef struct packed {
      logic [HANDLE_OUT_W-1:0] handle_out;
      logic [OBJECT_W-1:0]     object_out;
      logic [STATUS_W-1:0]     status;
   } rsp_item_type;

   typedef struct packed {
      logic [OBJECT_W-1:0] object;
      logic [TYPE_W-1:0]   otype;
   } slot_entry_type;

   typedef struct packed {
      logic           en;
      logic [SLOT_W-1:0] addr;
      slot_entry_type data;
   } mem_wr_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] slot;
      logic              value;
   } occ_upd_type;

   typedef struct packed {
      logic              hit;
      logic              last;
      logic [SCAN_W-1:0] index;
   } scan_res_type;

endpackage

### hdl/hta_if.sv
// ----------------------------------------------------------------------------
// hta_if - handle table allocator channel interfaces
// Request, response and register write channels, each a valid/ready
// transfer with its payload.
// ----------------------------------------------------------------------------
interface hta_req_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   action;
   logic [hta_pkg::HANDLE_W-1:0] handle;
   logic [hta_pkg::OBJECT_W-1:0] object;
   logic [hta_pkg::TYPE_W-1:0]   object_type;
   logic [hta_pkg::TYPE_W-1:0]   want_type;

   modport source (output valid, action, handle, object, object_type, want_type,
                   input ready);
   modport sink   (input valid, action, handle, object, object_type, want_type,
                   output ready);
endinterface

interface hta_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [hta_pkg::HANDLE_OUT_W-1:0] handle_out;
   logic [hta_pkg::OBJECT_W-1:0]     object_out;
   logic [hta_pkg::STATUS_W-1:0]     status;

   modport source (output valid, handle_out, object_out, status, input ready);
   modport sink   (input valid, handle_out, object_out, status, output ready);
endinterface

interface hta_csr_if;
   logic                            valid;
   logic                            ready;
   logic [hta_pkg::CSR_INDEX_W-1:0] index;
   logic [hta_pkg::OBJECT_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### hdl/hta_slot_mem.sv
// ----------------------------------------------------------------------------
// hta_slot_mem - slot storage
// One entry per slot holding object and type; one write port and one
// registered read port.
// ----------------------------------------------------------------------------
module hta_slot_mem (
   input  logic                          clock,
   input  hta_pkg::mem_wr_type           wr,
   input  logic                          rd_en,
   input  logic [hta_pkg::SLOT_W-1:0]    rd_addr,
   output hta_pkg::slot_entry_type       rd_data
);

   hta_pkg::slot_entry_type mem [hta_pkg::CAPACITY];
   hta_pkg::slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/hta_free_scan.sv
// ----------------------------------------------------------------------------
// hta_free_scan - slot occupancy map and free slot scanner
// Holds one occupied bit per slot and walks the map one chunk per cycle while
// scan_step is high, encoding the lowest free slot of the current chunk.
// ----------------------------------------------------------------------------
module hta_free_scan (
   input  logic                       clock,
   input  logic                       reset,
   input  hta_pkg::occ_upd_type       occ_upd,
   input  logic [hta_pkg::SLOT_W-1:0] query_slot,
   output logic                       query_occ,
   input  logic                       scan_start,
   input  logic                       scan_step,
   output hta_pkg::scan_res_type      scan_res
);

   logic [hta_pkg::CHUNK_W-1:0]     occ_ff [hta_pkg::NCHUNK];
   logic [hta_pkg::CHUNK_IDX_W-1:0] chunk_ff;
   logic [hta_pkg::CHUNK_IDX_W-1:0] chunk_in;
   logic [hta_pkg::SCAN_W-1:0]      upd_idx;
   logic [hta_pkg::SCAN_W-1:0]      qry_idx;
   logic [hta_pkg::CHUNK_W-1:0]     free_bits;
   logic [hta_pkg::CHUNK_LOG-1:0]   free_pos;
   logic                            chunk_last;

   assign upd_idx = hta_pkg::SCAN_W'(occ_upd.slot);
   assign qry_idx = hta_pkg::SCAN_W'(query_slot);

   // pad bits past the capacity stay occupied
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < hta_pkg::NCHUNK; c++) begin
            for (int b = 0; b < hta_pkg::CHUNK_W; b++) begin
               occ_ff[c][b] <= (c * hta_pkg::CHUNK_W + b >= hta_pkg::CAPACITY);
            end
         end
      end else if (occ_upd.en) begin
         occ_ff[upd_idx[hta_pkg::SCAN_W-1:hta_pkg::CHUNK_LOG]]
               [upd_idx[hta_pkg::CHUNK_LOG-1:0]] <= occ_upd.value;
      end
   end

   assign query_occ = occ_ff[qry_idx[hta_pkg::SCAN_W-1:hta_pkg::CHUNK_LOG]]
                            [qry_idx[hta_pkg::CHUNK_LOG-1:0]];

   assign free_bits  = ~occ_ff[chunk_ff];
   assign chunk_last = (chunk_ff == hta_pkg::CHUNK_IDX_W'(hta_pkg::NCHUNK - 1));

   always_comb begin
      free_pos = '0;
      for (int b = hta_pkg::CHUNK_W - 1; b >= 0; b--) begin
         if (free_bits[b]) begin
            free_pos = hta_pkg::CHUNK_LOG'(b);
         end
      end
   end

   always_comb begin
      chunk_in = chunk_ff;
      if (scan_start) begin
         chunk_in = '0;
      end else if (scan_step && !(|free_bits) && !chunk_last) begin
         chunk_in = chunk_ff + hta_pkg::CHUNK_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff <= '0;
      end else begin
         chunk_ff <= chunk_in;
      end
   end

   assign scan_res.hit   = |free_bits;
   assign scan_res.last  = chunk_last;
   assign scan_res.index = {chunk_ff, free_pos};

endmodule

### hdl/handle_table_allocator.sv
// ----------------------------------------------------------------------------
// handle_table_allocator - object handle table
// Requests arrive on req_chan (allocate, lookup, replace, close) and each
// gives exactly one response on rsp_chan, in order. csr_chan writes the self
// object and its type; it is always ready. The user must write it only while
// the block is idle; the block itself does not enforce this.
// One request is worked at a time; req_chan is ready only in the idle state.
// Path from request transfer to response: a lookup of a slot reads the slot
//   memory in the read state; other lookups, replace, close and allocate of
//   object 0 go straight to the done state; allocate walks k (1 to
//   CAPACITY/8) 8-slot chunks of the occupancy map in the scan state to reach
//   the lowest free slot; out of memory walks all CAPACITY/8 chunks.
// req_chan is ready again in the cycle the response turns valid.
// The response sits in an output register; the next request is taken while
// it waits, and that request's result holds until the register is free.
// Reset is synchronous: every slot reads empty, the usable size returns to
// its initial value, self object 0 with type 1. Nothing needs clearing in
// the slot memory; the occupancy map decides emptiness.
// ----------------------------------------------------------------------------
module handle_table_allocator (
   input  logic   clock,
   input  logic   reset,
   hta_req_if.sink   req_chan,
   hta_rsp_if.source rsp_chan,
   hta_csr_if.sink   csr_chan
);

   hta_pkg::state_type      state_ff, state_in;
   hta_pkg::req_item_type   item_ff, item_in;
   hta_pkg::rsp_item_type   res_ff, res_in;
   hta_pkg::rsp_item_type   rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [hta_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic [hta_pkg::SIZE_W-1:0] size_ff, size_in;
   logic [hta_pkg::OBJECT_W-1:0] self_object_ff;
   logic [hta_pkg::TYPE_W-1:0]   self_type_ff;

   hta_pkg::mem_wr_type     mem_wr;
   logic                    mem_rd_en;
   hta_pkg::slot_entry_type mem_rd_data;
   hta_pkg::occ_upd_type    occ_upd;
   hta_pkg::scan_res_type   scan_res;
   logic                    scan_start;
   logic                    scan_step;
   logic [hta_pkg::SLOT_W-1:0] query_slot;
   logic                    query_occ;

   logic                        req_ready;
   logic                        accept;
   logic                        in_range;
   logic                        self_hit;
   logic                        can_load;
   logic [hta_pkg::HANDLE_W-1:0] handle_m1;
   logic [hta_pkg::SLOT_W-1:0]   req_slot;
   logic [hta_pkg::SLOT_W-1:0]   scan_slot;
   logic [hta_pkg::SIZE_W-1:0]   scan_handle;
   logic [hta_pkg::SUM_W-1:0]    grow_sum;
   logic                         scan_in_size;
   hta_pkg::action_type          req_action;

   hta_slot_mem u_slot_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_en   (mem_rd_en),
      .rd_addr (req_slot),
      .rd_data (mem_rd_data)
   );

   hta_free_scan u_free_scan (
      .clock      (clock),
      .reset      (reset),
      .occ_upd    (occ_upd),
      .query_slot (query_slot),
      .query_occ  (query_occ),
      .scan_start (scan_start),
      .scan_step  (scan_step),
      .scan_res   (scan_res)
   );

   assign req_ready  = (state_ff == hta_pkg::ST_IDLE);
   assign accept     = req_chan.valid && req_ready;
   assign req_action = hta_pkg::action_type'(req_chan.action);
   assign handle_m1  = req_chan.handle - hta_pkg::HANDLE_W'(1);
   assign req_slot   = handle_m1[hta_pkg::SLOT_W-1:0];
   assign in_range   = (req_chan.handle != '0) &&
                       (req_chan.handle <= hta_pkg::HANDLE_W'(size_ff));
   assign self_hit   = (req_chan.handle == hta_pkg::SELF_HANDLE) &&
                       (self_object_ff != '0) &&
                       ((req_chan.want_type == hta_pkg::TYPE_ANY) ||
                        (req_chan.want_type == self_type_ff));
   assign query_slot = (state_ff == hta_pkg::ST_IDLE) ? req_slot : slot_ff;
   assign can_load   = !rsp_valid_ff || rsp_chan.ready;

   assign scan_slot    = hta_pkg::SLOT_W'(scan_res.index);
   assign scan_handle  = hta_pkg::SIZE_W'(scan_res.index) + hta_pkg::SIZE_W'(1);
   assign scan_in_size = hta_pkg::SUM_W'(scan_res.index) < hta_pkg::SUM_W'(size_ff);
   assign grow_sum     = hta_pkg::SUM_W'(size_ff) + hta_pkg::SUM_W'(hta_pkg::GROW_STEP);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hta_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = hta_pkg::ST_DONE;
               if (req_action == hta_pkg::ACT_ALLOC && req_chan.object != '0) begin
                  state_in = hta_pkg::ST_SCAN;
               end else if (req_action == hta_pkg::ACT_LOOKUP && in_range) begin
                  state_in = hta_pkg::ST_READ;
               end
            end
         end
         hta_pkg::ST_READ: begin
            state_in = hta_pkg::ST_DONE;
         end
         hta_pkg::ST_SCAN: begin
            if (scan_res.hit || scan_res.last) begin
               state_in = hta_pkg::ST_DONE;
            end
         end
         hta_pkg::ST_DONE: begin
            if (can_load) begin
               state_in = hta_pkg::ST_IDLE;
            end
         end
         default: state_in = hta_pkg::ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      item_in      = item_ff;
      res_in       = res_ff;
      slot_in      = slot_ff;
      size_in      = size_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      mem_wr       = '0;
      mem_rd_en    = 1'b0;
      occ_upd      = '0;
      scan_start   = 1'b0;
      scan_step    = 1'b0;

      unique case (state_ff)
         hta_pkg::ST_IDLE: begin
            if (accept) begin
               item_in.action      = req_chan.action;
               item_in.handle      = req_chan.handle;
               item_in.object      = req_chan.object;
               item_in.object_type = req_chan.object_type;
               item_in.want_type   = req_chan.want_type;
               slot_in             = req_slot;
               res_in              = '0;
               res_in.status       = hta_pkg::STATUS_OK;
               unique case (req_action)
                  hta_pkg::ACT_ALLOC: begin
                     if (req_chan.object == '0) begin
                        res_in.status = hta_pkg::STATUS_INVALID;
                     end else begin
                        scan_start = 1'b1;
                     end
                  end
                  hta_pkg::ACT_LOOKUP: begin
                     if (in_range) begin
                        mem_rd_en = 1'b1;
                     end else if (self_hit) begin
                        res_in.object_out = self_object_ff;
                     end else begin
                        res_in.status = hta_pkg::STATUS_INVALID;
                     end
                  end
                  hta_pkg::ACT_REPLACE: begin
                     if (in_range) begin
                        mem_wr.en         = 1'b1;
                        mem_wr.addr       = req_slot;
                        mem_wr.data.object = req_chan.object;
                        mem_wr.data.otype  = req_chan.object_type;
                        occ_upd.en        = 1'b1;
                        occ_upd.slot      = req_slot;
                        occ_upd.value     = (req_chan.object != '0);
                     end else begin
                        res_in.status = hta_pkg::STATUS_INVALID;
                     end
                  end
                  hta_pkg::ACT_CLOSE: begin
                     if (in_range && query_occ) begin
                        occ_upd.en    = 1'b1;
                        occ_upd.slot  = req_slot;
                        occ_upd.value = 1'b0;
                     end else begin
                        res_in.status = hta_pkg::STATUS_INVALID;
                     end
                  end
                  default: res_in.status = hta_pkg::STATUS_INVALID;
               endcase
            end
         end
         hta_pkg::ST_READ: begin
            if (query_occ && ((item_ff.want_type == hta_pkg::TYPE_ANY) ||
                              (item_ff.want_type == mem_rd_data.otype))) begin
               res_in.object_out = mem_rd_data.object;
            end else begin
               res_in.status = hta_pkg::STATUS_INVALID;
            end
         end
         hta_pkg::ST_SCAN: begin
            scan_step = 1'b1;
            if (scan_res.hit) begin
               // lowest free slot at or past the usable size is the first new slot
               if (!scan_in_size) begin
                  size_in = (grow_sum > hta_pkg::SUM_W'(hta_pkg::CAPACITY)) ?
                            hta_pkg::SIZE_W'(hta_pkg::CAPACITY) :
                            hta_pkg::SIZE_W'(grow_sum);
               end
               mem_wr.en          = 1'b1;
               mem_wr.addr        = scan_slot;
               mem_wr.data.object = item_ff.object;
               mem_wr.data.otype  = item_ff.object_type;
               occ_upd.en         = 1'b1;
               occ_upd.slot       = scan_slot;
               occ_upd.value      = 1'b1;
               res_in.handle_out  = hta_pkg::HANDLE_OUT_W'(scan_handle);
            end else if (scan_res.last) begin
               res_in.status = hta_pkg::STATUS_NO_MEM;
            end
         end
         hta_pkg::ST_DONE: begin
            if (can_load) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hta_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         size_ff      <= hta_pkg::SIZE_W'(hta_pkg::TABLE_INIT);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         size_ff      <= size_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
      slot_ff <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         self_object_ff <= hta_pkg::SELF_OBJECT_RESET;
         self_type_ff   <= hta_pkg::SELF_TYPE_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            hta_pkg::REG_SELF_OBJECT: self_object_ff <= csr_chan.data;
            hta_pkg::REG_SELF_TYPE:   self_type_ff   <= csr_chan.data[hta_pkg::TYPE_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = req_ready;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.handle_out = rsp_ff.handle_out;
   assign rsp_chan.object_out = rsp_ff.object_out;
   assign rsp_chan.status     = rsp_ff.status;

endmodule
